@@ hdl/tlmr_pkg.sv @@
// ----------------------------------------------------------------------------
// tlmr_pkg: shared types and constants of the text line to mouse report block
// Character codes, parser phases and the item and report beat structures.
// ----------------------------------------------------------------------------
`default_nettype none

package tlmr_pkg;

	// Character codes recognised by the parser.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	// Magnitude saturation point (2^31).
	localparam logic [31:0] SAT_MAG = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	// Index of the field being parsed after the pipe.
	localparam logic [1:0] FLD_BUTTONS = 2'd0;
	localparam logic [1:0] FLD_X       = 2'd1;
	localparam logic [1:0] FLD_Y       = 2'd2;
	localparam logic [1:0] FLD_WHEEL   = 2'd3;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_SEEK,
		PH_BLANK,
		PH_NUM,
		PH_VALID,
		PH_DEAD
	} phase_t;

	// One input beat.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       host_mounted;
		logic       link_ready;
	} item_t;

	// One report beat.
	typedef struct packed {
		logic        [7:0]  buttons;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic signed [7:0]  wheel_move;
	} report_t;

endpackage

`default_nettype wire

@@ hdl/tlmr_in_reg.sv @@
// ----------------------------------------------------------------------------
// tlmr_in_reg: input register stage
// Captures one input beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmr_in_reg (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  tlmr_pkg::item_t in_item,
	input  wire            take,
	output logic           valid_s1,
	output tlmr_pkg::item_t item_s1
);
	import tlmr_pkg::*;

	logic accept;

	// The stage is stalled only when it holds a beat the parser cannot take.
	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ hdl/tlmr_parse.sv @@
// ----------------------------------------------------------------------------
// tlmr_parse: per-byte line parser and report builder
// Holds the line state and carry-over, and updates them once per beat taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmr_parse #(
	parameter int LINE_BYTES = 128
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              valid_s1,
	input  tlmr_pkg::item_t  item_s1,
	input  wire              out_free,
	output logic             fire,
	output logic             res_load,
	output tlmr_pkg::report_t report
);
	import tlmr_pkg::*;

	localparam int LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BYTES - 1);

	// State registers and their next values.
	logic [LEN_W-1:0] len_q, len_d;
	phase_t           phase_q, phase_d;
	logic [1:0]       fld_q, fld_d;
	logic             neg_q, neg_d;
	logic             seen_q, seen_d;
	logic [31:0]      mag_q, mag_d;
	logic [7:0]       held_btn_q, held_btn_d;
	logic [15:0]      held_x_q, held_x_d;
	logic [15:0]      held_y_q, held_y_d;
	logic [15:0]      carry_x_q, carry_x_d;
	logic [15:0]      carry_y_q, carry_y_d;
	logic [7:0]       carry_w_q, carry_w_d;

	logic [7:0]  c;
	logic        is_eol;
	logic        is_digit;
	logic        is_blank;
	logic        line_ok;
	logic        res_gen;
	logic [35:0] prod;
	logic [31:0] mag_dig;
	logic [31:0] num_val;

	assign c        = item_s1.rx_byte;
	assign is_eol   = (c == CH_LF) || (c == CH_CR);
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);

	// Line is valid when the wheel value is complete.
	assign line_ok = (phase_q == PH_VALID) ||
			((phase_q == PH_NUM) && (fld_q == FLD_WHEEL) && seen_q);

	// Decimal accumulate: magnitude times ten plus the digit, saturated at 2^31.
	assign prod = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {32'd0, c[3:0]};
	assign mag_dig = (prod > {4'd0, SAT_MAG}) ? SAT_MAG : prod[31:0];

	// Signed value of the number, saturated to the 32-bit range.
	assign num_val = neg_q ? (32'd0 - mag_q) : (mag_q[31] ? POS_MAX : mag_q);

	// A report is due when a valid line ends while mounted and the link is ready.
	assign res_gen = is_eol && (len_q != '0) && line_ok &&
			item_s1.host_mounted && item_s1.link_ready;

	assign fire     = valid_s1 && (out_free || !res_gen);
	assign res_load = fire && res_gen;

	// Report fields from the held values and the carry-over.
	assign report.buttons    = held_btn_q;
	assign report.move_x     = held_x_q + carry_x_q;
	assign report.move_y     = held_y_q + carry_y_q;
	assign report.wheel_move = num_val[7:0] + carry_w_q;

	// Next state for one character.
	always_comb begin
		len_d      = len_q;
		phase_d    = phase_q;
		fld_d      = fld_q;
		neg_d      = neg_q;
		seen_d     = seen_q;
		mag_d      = mag_q;
		held_btn_d = held_btn_q;
		held_x_d   = held_x_q;
		held_y_d   = held_y_q;
		carry_x_d  = carry_x_q;
		carry_y_d  = carry_y_q;
		carry_w_d  = carry_w_q;

		if (is_eol) begin
			if ((len_q != '0) && line_ok && item_s1.host_mounted) begin
				if (item_s1.link_ready) begin
					carry_x_d = '0;
					carry_y_d = '0;
					carry_w_d = '0;
				end else begin
					carry_x_d = carry_x_q + held_x_q;
					carry_y_d = carry_y_q + held_y_q;
					carry_w_d = carry_w_q + num_val[7:0];
				end
			end
			len_d   = '0;
			phase_d = PH_SEEK;
			neg_d   = 1'b0;
			seen_d  = 1'b0;
			mag_d   = '0;
		end else if (len_q < LEN_LAST) begin
			len_d = len_q + 1'b1;
			if (c == CH_NUL) begin
				// NUL ends the parsed text of the line.
				if (phase_q != PH_VALID) begin
					phase_d = line_ok ? PH_VALID : PH_DEAD;
				end
			end else begin
				unique case (phase_q)
					PH_SEEK: begin
						if (c == CH_PIPE) begin
							phase_d = PH_BLANK;
							fld_d   = FLD_BUTTONS;
						end
					end
					PH_BLANK: begin
						if (is_blank) begin
							phase_d = PH_BLANK;
						end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
							neg_d   = (c == CH_MINUS);
							phase_d = PH_NUM;
						end else if (is_digit) begin
							mag_d   = {28'd0, c[3:0]};
							seen_d  = 1'b1;
							phase_d = PH_NUM;
						end else begin
							phase_d = PH_DEAD;
						end
					end
					PH_NUM: begin
						if (is_digit) begin
							mag_d  = mag_dig;
							seen_d = 1'b1;
						end else if (!seen_q) begin
							phase_d = PH_DEAD;
						end else if (fld_q == FLD_WHEEL) begin
							phase_d = PH_VALID;
						end else if (c == CH_SLASH) begin
							case (fld_q)
								FLD_BUTTONS: held_btn_d = num_val[7:0];
								FLD_X:       held_x_d   = num_val[15:0];
								default:     held_y_d   = num_val[15:0];
							endcase
							neg_d   = 1'b0;
							seen_d  = 1'b0;
							mag_d   = '0;
							fld_d   = fld_q + 2'd1;
							phase_d = PH_BLANK;
						end else begin
							phase_d = PH_DEAD;
						end
					end
					PH_VALID, PH_DEAD: begin
						phase_d = phase_q;
					end
					default: begin
						phase_d = PH_DEAD;
					end
				endcase
			end
		end else begin
			// Overlong line: drop the character and restart.
			len_d   = '0;
			phase_d = PH_SEEK;
			neg_d   = 1'b0;
			seen_d  = 1'b0;
			mag_d   = '0;
		end
	end

	// State register, updated when a beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			phase_q    <= PH_SEEK;
			fld_q      <= FLD_BUTTONS;
			neg_q      <= 1'b0;
			seen_q     <= 1'b0;
			mag_q      <= '0;
			held_btn_q <= '0;
			held_x_q   <= '0;
			held_y_q   <= '0;
			carry_x_q  <= '0;
			carry_y_q  <= '0;
			carry_w_q  <= '0;
		end else if (fire) begin
			len_q      <= len_d;
			phase_q    <= phase_d;
			fld_q      <= fld_d;
			neg_q      <= neg_d;
			seen_q     <= seen_d;
			mag_q      <= mag_d;
			held_btn_q <= held_btn_d;
			held_x_q   <= held_x_d;
			held_y_q   <= held_y_d;
			carry_x_q  <= carry_x_d;
			carry_y_q  <= carry_y_d;
			carry_w_q  <= carry_w_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/tlmr_out_reg.sv @@
// ----------------------------------------------------------------------------
// tlmr_out_reg: report output register
// Holds one report beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmr_out_reg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               res_load,
	input  tlmr_pkg::report_t report,
	input  wire               out_stall,
	output logic              valid_s2,
	output logic              out_free,
	output tlmr_pkg::report_t rpt_s2
);
	import tlmr_pkg::*;

	// The register can be loaded when empty or when its beat leaves now.
	assign out_free = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (res_load) begin
			rpt_s2 <= report;
		end
	end

endmodule

`default_nettype wire

@@ hdl/text_line_to_mouse_report_top.sv @@
// ----------------------------------------------------------------------------
// text_line_to_mouse_report_top: serial text line to mouse report converter
// Path: a line end is held in the input register, then its report in the output register.
// Throughput: one byte per cycle while a waiting report does not stall the parser.
// Reset: asynchronous; clears the line state, carry-over and both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_to_mouse_report_top #(
	parameter int LINE_BYTES = 128
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [7:0]        rx_byte,
	input  wire               host_mounted,
	input  wire               link_ready,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [7:0]        buttons,
	output logic signed [15:0] move_x,
	output logic signed [15:0] move_y,
	output logic signed [7:0] wheel_move
);
	import tlmr_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    fire;
	logic    res_load;
	logic    out_free;
	report_t report;
	report_t rpt_s2;

	assign in_item.rx_byte      = rx_byte;
	assign in_item.host_mounted = host_mounted;
	assign in_item.link_ready   = link_ready;

	// Input register stage.
	tlmr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Parser and carry-over state.
	tlmr_parse #(
		.LINE_BYTES (LINE_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.fire     (fire),
		.res_load (res_load),
		.report   (report)
	);

	// Report output register.
	tlmr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.report    (report),
		.out_stall (out_stall),
		.valid_s2  (out_valid),
		.out_free  (out_free),
		.rpt_s2    (rpt_s2)
	);

	assign buttons    = rpt_s2.buttons;
	assign move_x     = rpt_s2.move_x;
	assign move_y     = rpt_s2.move_y;
	assign wheel_move = rpt_s2.wheel_move;

	// A report is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!out_valid || !out_stall))
		else $error("report loaded over a waiting report beat");

	// The input side stalls only while the input stage holds a beat.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	// A new report appears only after the parser loaded one.
	a_report_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res_load))
		else $error("report beat appeared without a parser load");

	// The parser takes a beat only while the input stage holds one.
	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> valid_s1)
		else $error("parser took a beat from an empty input stage");

endmodule

`default_nettype wire
